>>> hdl/assert_macros.svh
// Assertion helpers used by the RTL file cst_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SEMS    = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 8;

  localparam int SLOT_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QPOS_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ACT_W   = $clog2(NUM_SEMS + 1);
  localparam int WADDR_W = SLOT_W + QPOS_W;
  localparam int WDEPTH  = NUM_SEMS * QUEUE_DEPTH;

  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_AUTO    = 3'd1;
  localparam logic [2:0] REQ_DESTROY = 3'd2;
  localparam logic [2:0] REQ_WAIT    = 3'd3;
  localparam logic [2:0] REQ_SIGNAL  = 3'd4;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_BAD_ID     = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

  localparam logic [31:0] FIRST_AUTO_ID = 32'd10;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Request as classified by the front part.
  typedef struct packed {
    logic [2:0]          req;
    logic [31:0]         id;
    logic [15:0]         init;
    logic [PID_BITS-1:0] pid;
  } cmd_t;

endpackage

>>> hdl/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Input side: register the request, trim the PID, push into a short queue.
// ----------------------------------------------------------------------------
module cst_front import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] sem_id,
  input  logic [15:0] init_value,
  input  logic [7:0]  caller_pid,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t q0, q1;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q0;
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  cmd_t incoming;
  always_comb begin
    incoming.req  = req_type;
    incoming.id   = sem_id;
    incoming.init = init_value;
    incoming.pid  = caller_pid[PID_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    // two-entry queue, head in q0
    if (pop) begin
      q0 <= (cnt == 2'd2) ? q1 : incoming;
      if (push) q1 <= incoming;
    end else if (push) begin
      if (cnt == 2'd0) q0 <= incoming;
      else q1 <= incoming;
    end
  end

endmodule

>>> hdl/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back
// Execution side: table search, auto-ID search, queue update, result hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cst_back import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] assigned_id,
  output logic        must_block,
  output logic        woken_valid,
  output logic [7:0]  woken_pid
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_AUTO = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  cmd_t cur;

  logic [31:0]        ids    [NUM_SEMS];
  logic [15:0]        counts [NUM_SEMS];
  logic [QPOS_W-1:0]  heads  [NUM_SEMS];
  logic [QPOS_W-1:0]  tails  [NUM_SEMS];
  logic [QFILL_W-1:0] fill   [NUM_SEMS];
  logic [ACT_W-1:0]   active;

  logic [PID_BITS-1:0] wmem [WDEPTH];
  logic [PID_BITS-1:0] wrd;

  // one slot per cycle is compared against the target ID
  logic [SLOT_W:0]   idx;
  logic [31:0]       target;
  logic              hit, has_free;
  logic [SLOT_W-1:0] hit_slot, free_slot;

  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W:0]   idx_next;
  assign cur_slot = idx[SLOT_W-1:0];
  assign idx_next = idx + 1'b1;

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      active    <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        ids[i]    <= '0;
        counts[i] <= '0;
        heads[i]  <= '0;
        tails[i]  <= '0;
        fill[i]   <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur      <= cmd;
            idx      <= '0;
            hit      <= 1'b0;
            has_free <= 1'b0;
            target   <= (cmd.req == REQ_AUTO) ? FIRST_AUTO_ID : cmd.id;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // find the target ID and the first free slot
          if (ids[cur_slot] == target && target != '0 && !hit) begin
            hit      <= 1'b1;
            hit_slot <= cur_slot;
          end
          if (ids[cur_slot] == '0 && !has_free) begin
            has_free  <= 1'b1;
            free_slot <= cur_slot;
          end
          idx <= idx_next;
          if (idx_next == (SLOT_W+1)'(NUM_SEMS)) begin
            state <= (cur.req == REQ_AUTO) ? S_AUTO : S_EXEC;
          end
        end
        S_AUTO: begin
          // on a hit, try the next candidate ID with a fresh pass
          if (hit || (ids[cur_slot] == target)) begin
            target <= target + 32'd1;
            hit    <= 1'b0;
            idx    <= '0;
            state  <= S_SCAN;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status      <= ST_DONE;
          assigned_id <= '0;
          must_block  <= 1'b0;
          woken_valid <= 1'b0;
          woken_pid   <= '0;
          state       <= S_OUT;
          case (cur.req)
            REQ_CREATE, REQ_AUTO: begin
              if (target == '0) begin
                status <= ST_BAD_ID;
              end else if (active >= ACT_W'(NUM_SEMS)) begin
                status <= ST_NO_SPACE;
              end else if (hit) begin
                status <= ST_BAD_ID;
              end else if (!has_free) begin
                status <= ST_NO_SPACE;
              end else begin
                ids[free_slot]    <= target;
                counts[free_slot] <= cur.init;
                heads[free_slot]  <= '0;
                tails[free_slot]  <= '0;
                fill[free_slot]   <= '0;
                active            <= active + 1'b1;
                assigned_id       <= target;
              end
            end
            REQ_DESTROY: begin
              if (!hit) begin
                status <= ST_BAD_ID;
              end else begin
                ids[hit_slot]    <= '0;
                counts[hit_slot] <= '0;
                heads[hit_slot]  <= '0;
                tails[hit_slot]  <= '0;
                fill[hit_slot]   <= '0;
                if (active != '0) active <= active - 1'b1;
              end
            end
            REQ_WAIT: begin
              if (!hit) begin
                status <= ST_BAD_ID;
              end else if (counts[hit_slot] != '0) begin
                counts[hit_slot] <= counts[hit_slot] - 16'd1;
              end else if (fill[hit_slot] >= QFILL_W'(QUEUE_DEPTH)) begin
                status <= ST_QUEUE_FULL;
              end else begin
                tails[hit_slot] <= (tails[hit_slot] == QPOS_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : tails[hit_slot] + 1'b1;
                fill[hit_slot]  <= fill[hit_slot] + 1'b1;
                must_block      <= 1'b1;
              end
            end
            REQ_SIGNAL: begin
              if (!hit) begin
                status <= ST_BAD_ID;
              end else if (fill[hit_slot] != '0) begin
                heads[hit_slot] <= (heads[hit_slot] == QPOS_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : heads[hit_slot] + 1'b1;
                fill[hit_slot]  <= fill[hit_slot] - 1'b1;
                woken_valid     <= 1'b1;
                state           <= S_READ;
              end else if (counts[hit_slot] != COUNT_MAX) begin
                counts[hit_slot] <= counts[hit_slot] + 16'd1;
              end
            end
            default: begin
            end
          endcase
        end
        S_READ: begin
          // waiter memory read lands now
          woken_pid <= 8'(wrd);
          state     <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // waiter memory: push on a blocking wait, registered read on a signal
  logic wwe;
  logic [WADDR_W-1:0] waddr, raddr;
  assign wwe = (state == S_EXEC) && (cur.req == REQ_WAIT) && hit &&
               (counts[hit_slot] == '0) && (fill[hit_slot] < QFILL_W'(QUEUE_DEPTH));
  assign waddr = {hit_slot, tails[hit_slot]};
  assign raddr = {hit_slot, heads[hit_slot]};

  always_ff @(posedge clk) begin
    if (wwe) wmem[waddr] <= cur.pid;
    wrd <= wmem[raddr];
  end

  `ASSERT_IMPLY(a_ready_idle, clk, rst, cmd_ready, state == S_IDLE && !out_valid,
    "ready outside idle")
  `ASSERT_NEXT(a_out_follows, clk, rst, state == S_OUT, out_valid,
    "result not raised")
  `ASSERT_IMPLY(a_active_range, clk, rst, 1'b1, active <= ACT_W'(NUM_SEMS),
    "active count overflow")

endmodule

>>> hdl/counting_semaphore_table_top.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table_top
// Table of counting semaphores with per-entry FIFOs of waiting processes.
// ----------------------------------------------------------------------------
// A request is queued, takes one pass over the table, one entry per cycle,
// and is then executed and its result presented. Auto-create repeats the
// pass for every candidate ID that is already in use. The front queue holds
// two requests so the source may run ahead of the search; the result is held
// in an output register until transferred.
module counting_semaphore_table_top import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] sem_id,
  input  logic [15:0] init_value,
  input  logic [7:0]  caller_pid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] assigned_id,
  output logic        must_block,
  output logic        woken_valid,
  output logic [7:0]  woken_pid
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // accept and queue requests
  cst_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .sem_id, .init_value,
    .caller_pid, .cmd_valid, .cmd_ready, .cmd
  );

  // search the table and carry out one request at a time
  cst_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
    .status, .assigned_id, .must_block, .woken_valid, .woken_pid
  );

endmodule
